>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the console rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // field widths
    localparam int CELL_ADDR_W = 11;
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;

    // character and attribute codes
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
    localparam logic [7:0] RESET_COLOR  = 8'h0F;

    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_NEWLINE,
        ST_SCROLL_RD,
        ST_SCROLL_WR,
        ST_BLANK,
        ST_WRITE,
        ST_CLEAR,
        ST_READ,
        ST_READ_WAIT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [7:0] color;
        logic [7:0] ch;
    } t_cell;

    typedef struct packed {
        logic                   we;
        logic [CELL_ADDR_W-1:0] addr;
        t_cell                  data;
    } t_ram_wr;

    typedef struct packed {
        t_cmd                   cmd;
        logic [7:0]             char_code;
        logic [CELL_ADDR_W-1:0] cell_address;
    } t_in_word;

    typedef struct packed {
        logic [CELL_ADDR_W-1:0] cursor_position;
        logic [ROW_W-1:0]       cursor_row;
        logic [COL_W-1:0]       cursor_column;
        logic [7:0]             read_char;
        logic [7:0]             read_color;
    } t_out_word;

endpackage

>>> src/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console engine: put, newline with scroll, clear and cell read
//
// channel   direction  handshake                  payload
// in        input      i_in_valid / o_in_ready    i_in_data   (t_in_word)
// out       output     o_out_valid / i_out_ready  o_out_data  (t_out_word)
// cfg       input      i_cfg_we                   i_cfg_wdata (text color)
//
// one word at a time, o_in_ready low while it is worked on; a put writes the
// cell, after a newline if the row was full; a newline on the last row
// scrolls, one cell per store read and write pair, then blanks the last row;
// clear blanks every cell; read waits on the registered store; out of range
// read or unused command skips the store. reset blanks the store, ready low;
// cfg writes taken always; a stalled result holds while the next word is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module text_console_writer
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata
);

    logic [7:0]             r_text_color;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_data,  n_out_data;

    logic                   w_out_free;
    logic                   w_res_valid;
    t_out_word              w_res_data;
    t_ram_wr                w_ram_wr;
    logic [CELL_ADDR_W-1:0] w_ram_raddr;
    t_cell                  w_ram_rdata;

    // attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= RESET_COLOR;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_wdata;
        end
    end

    // output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        if (w_out_free) begin
            n_out_valid = w_res_valid;
            n_out_data  = w_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // sequencer
    tcw_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_text_color (r_text_color),
        .i_out_free   (w_out_free),
        .o_res_valid  (w_res_valid),
        .o_res_data   (w_res_data),
        .o_ram_wr     (w_ram_wr),
        .o_ram_raddr  (w_ram_raddr),
        .i_ram_rdata  (w_ram_rdata)
    );

    // screen store
    tcw_cell_ram u_ram (
        .i_clk   (i_clk),
        .i_wr    (w_ram_wr),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // checks
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready,
        !o_in_ready, "ready stayed high after a word was taken")
    `ASSERT_IMPLIES(a_cursor_in_range, i_clk, i_rst_n, o_out_valid,
        (o_out_data.cursor_column <= COL_W'(COLUMNS)) &&
        (o_out_data.cursor_row < ROW_W'(ROWS)), "cursor out of range")
    `ASSERT_IMPLIES(a_position_match, i_clk, i_rst_n, o_out_valid,
        o_out_data.cursor_position == CELL_ADDR_W'(int'(o_out_data.cursor_row) *
        COLUMNS + int'(o_out_data.cursor_column)), "cursor position mismatch")

endmodule

>>> src/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// screen cell store, one write port and one registered read port
// ----------------------------------------------------------------------------
module tcw_cell_ram
    import tcw_pkg::*;
(
    input  logic                   i_clk,
    input  t_ram_wr                i_wr,
    input  logic [CELL_ADDR_W-1:0] i_raddr,
    output t_cell                  o_rdata
);

    t_cell r_mem [CELLS];
    t_cell r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/tcw_seq.sv
// ----------------------------------------------------------------------------
// tcw_seq
// command sequencer: cursor, index walker for clear, scroll and blank
// ----------------------------------------------------------------------------
module tcw_seq
    import tcw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_data,
    input  logic [7:0] i_text_color,
    input  logic       i_out_free,
    output logic       o_res_valid,
    output t_out_word  o_res_data,
    output t_ram_wr    o_ram_wr,
    output logic [CELL_ADDR_W-1:0] o_ram_raddr,
    input  t_cell      i_ram_rdata
);

    t_state                 r_state, n_state;
    logic [CELL_ADDR_W-1:0] r_idx,   n_idx;
    logic [ROW_W-1:0]       r_row,   n_row;
    logic [COL_W-1:0]       r_col,   n_col;
    logic [CELL_ADDR_W-1:0] r_base,  n_base;
    logic                   r_put,   n_put;
    logic [7:0]             r_char,  n_char;
    t_cell                  r_rd,    n_rd;

    logic                   w_idx_last;
    t_state                 w_after_nl;

    // shared index compare
    assign w_idx_last = (r_idx == CELL_ADDR_W'(CELLS - 1));
    assign w_after_nl = r_put ? ST_WRITE : ST_RESULT;

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_idx   <= '0;
            r_row   <= '0;
            r_col   <= '0;
            r_base  <= '0;
            r_put   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_row   <= n_row;
            r_col   <= n_col;
            r_base  <= n_base;
            r_put   <= n_put;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_char <= n_char;
        r_rd   <= n_rd;
    end

    // next state and outputs
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_row       = r_row;
        n_col       = r_col;
        n_base      = r_base;
        n_put       = r_put;
        n_char      = r_char;
        n_rd        = r_rd;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram_wr    = '0;
        o_ram_raddr = r_idx;

        unique case (r_state)
            // blank the store after reset in the reset attribute
            ST_INIT: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_idx;
                o_ram_wr.data = '{color: RESET_COLOR, ch: BLANK_CHAR};
                if (w_idx_last) begin
                    n_idx   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // take a command word
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_rd   = '0;
                    n_put  = 1'b0;
                    n_char = i_in_data.char_code;
                    unique case (i_in_data.cmd)
                        CMD_PUT: begin
                            if (i_in_data.char_code == NEWLINE_CHAR) begin
                                n_state = ST_NEWLINE;
                            end else if (r_col == COL_W'(COLUMNS)) begin
                                n_put   = 1'b1;
                                n_state = ST_NEWLINE;
                            end else begin
                                n_state = ST_WRITE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_idx   = '0;
                            n_state = ST_CLEAR;
                        end
                        CMD_READ: begin
                            if (i_in_data.cell_address < CELL_ADDR_W'(CELLS)) begin
                                n_idx   = i_in_data.cell_address;
                                n_state = ST_READ;
                            end else begin
                                n_state = ST_RESULT;
                            end
                        end
                        CMD_NOP: begin
                            n_state = ST_RESULT;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end

            // move down a row, or scroll on the last row
            ST_NEWLINE: begin
                n_col = '0;
                if (r_row != ROW_W'(ROWS - 1)) begin
                    n_row   = r_row + 1'b1;
                    n_base  = r_base + CELL_ADDR_W'(COLUMNS);
                    n_state = w_after_nl;
                end else begin
                    n_idx   = CELL_ADDR_W'(COLUMNS);
                    n_state = ST_SCROLL_RD;
                end
            end

            // fetch the cell one row below
            ST_SCROLL_RD: begin
                n_state = ST_SCROLL_WR;
            end

            // store it one row up
            ST_SCROLL_WR: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_idx - CELL_ADDR_W'(COLUMNS);
                o_ram_wr.data = i_ram_rdata;
                if (w_idx_last) begin
                    n_idx   = CELL_ADDR_W'(LAST_ROW_BASE);
                    n_state = ST_BLANK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_SCROLL_RD;
                end
            end

            // blank the last row
            ST_BLANK: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_idx;
                o_ram_wr.data = '{color: i_text_color, ch: BLANK_CHAR};
                if (w_idx_last) begin
                    n_idx   = '0;
                    n_state = w_after_nl;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // character at the cursor, then advance
            ST_WRITE: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_base + CELL_ADDR_W'(r_col);
                o_ram_wr.data = '{color: i_text_color, ch: r_char};
                n_col         = r_col + 1'b1;
                n_state       = ST_RESULT;
            end

            // blank every cell and home the cursor
            ST_CLEAR: begin
                o_ram_wr.we   = 1'b1;
                o_ram_wr.addr = r_idx;
                o_ram_wr.data = '{color: i_text_color, ch: BLANK_CHAR};
                if (w_idx_last) begin
                    n_idx   = '0;
                    n_row   = '0;
                    n_col   = '0;
                    n_base  = '0;
                    n_state = ST_RESULT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end

            // read address presented
            ST_READ: begin
                n_state = ST_READ_WAIT;
            end

            // read data back from the store
            ST_READ_WAIT: begin
                n_rd    = i_ram_rdata;
                n_state = ST_RESULT;
            end

            // hand the result word over once the output register is free
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // result word
    assign o_res_data.cursor_position = r_base + CELL_ADDR_W'(r_col);
    assign o_res_data.cursor_row      = r_row;
    assign o_res_data.cursor_column   = r_col;
    assign o_res_data.read_char       = r_rd.ch;
    assign o_res_data.read_color      = r_rd.color;

endmodule
